// ----- sv/crtc_pkg.sv -----
`default_nettype none
package crtc_pkg;

    localparam int NUM_DIV = 7;

    // Positions of the radix divisors in the bit-serial chain (fastest first)
    localparam int DIV_CORE  = 0;
    localparam int DIV_NOC_X = 1;
    localparam int DIV_NOC_Y = 2;
    localparam int DIV_NOC_Z = 3;
    localparam int DIV_NODE  = 4;
    localparam int DIV_NET_X = 5;
    localparam int DIV_NET_Y = 6;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_NET_WIDTH  = 3'd0;
    localparam t_reg_idx REG_NET_HEIGHT = 3'd1;
    localparam t_reg_idx REG_NET_DEPTH  = 3'd2;
    localparam t_reg_idx REG_NOC_WIDTH  = 3'd3;
    localparam t_reg_idx REG_NOC_HEIGHT = 3'd4;
    localparam t_reg_idx REG_NOC_ZDIM   = 3'd5;
    localparam t_reg_idx REG_CORES_RTR  = 3'd6;
    localparam t_reg_idx REG_NODES_RTR  = 3'd7;

    typedef logic [6:0] t_rad;
    typedef logic [5:0] t_rem;

    typedef struct packed {
        t_rad [NUM_DIV-1:0] div;
        t_rad               depth;
    } t_cfg;

    typedef t_rem [NUM_DIV-1:0] t_rems;

    // Clamp a written radix into 1..64
    function automatic t_rad clamp_rad(input t_rad v);
        t_rad r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > 7'd64) begin
            r = 7'd64;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // One long-division step: returns {quotient bit, new remainder}
    function automatic logic [6:0] div_step(input t_rem rem, input logic b, input t_rad d);
        logic [6:0] t;
        logic [6:0] r;
        t = {rem, b};
        if (t >= d) begin
            r = {1'b1, 6'(t - d)};
        end else begin
            r = {1'b0, t[5:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/crtc_cfg_regs.sv -----
`default_nettype none
module crtc_cfg_regs (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire crtc_pkg::t_reg_idx i_cfg_idx,
    input  wire crtc_pkg::t_rad   i_cfg_data,
    output crtc_pkg::t_cfg        o_cfg
);

    crtc_pkg::t_cfg r_cfg;
    crtc_pkg::t_cfg n_cfg;
    crtc_pkg::t_rad w_val;

    assign w_val = crtc_pkg::clamp_rad(i_cfg_data);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crtc_pkg::REG_NET_WIDTH:  n_cfg.div[crtc_pkg::DIV_NET_X] = w_val;
                crtc_pkg::REG_NET_HEIGHT: n_cfg.div[crtc_pkg::DIV_NET_Y] = w_val;
                crtc_pkg::REG_NET_DEPTH:  n_cfg.depth = w_val;
                crtc_pkg::REG_NOC_WIDTH:  n_cfg.div[crtc_pkg::DIV_NOC_X] = w_val;
                crtc_pkg::REG_NOC_HEIGHT: n_cfg.div[crtc_pkg::DIV_NOC_Y] = w_val;
                crtc_pkg::REG_NOC_ZDIM:   n_cfg.div[crtc_pkg::DIV_NOC_Z] = w_val;
                crtc_pkg::REG_CORES_RTR:  n_cfg.div[crtc_pkg::DIV_CORE] = w_val;
                crtc_pkg::REG_NODES_RTR:  n_cfg.div[crtc_pkg::DIV_NODE] = w_val;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < crtc_pkg::NUM_DIV; k++) begin
                r_cfg.div[k] <= 7'd1;
            end
            r_cfg.depth <= 7'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- sv/crtc_stage.sv -----
`default_nettype none
// One bit column of the chained divisions by the seven radices
module crtc_stage #(
    parameter int INDEX_BITS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  wire crtc_pkg::t_cfg    i_cfg,
    input  wire                    i_valid,
    input  wire [INDEX_BITS-1:0]   i_idx,
    input  wire crtc_pkg::t_rems   i_rems,
    input  wire [INDEX_BITS-1:0]   i_node,
    input  wire [INDEX_BITS-1:0]   i_rtr,
    input  wire [INDEX_BITS-1:0]   i_netz,
    output logic                   o_valid,
    output logic [INDEX_BITS-1:0]  o_idx,
    output crtc_pkg::t_rems        o_rems,
    output logic [INDEX_BITS-1:0]  o_node,
    output logic [INDEX_BITS-1:0]  o_rtr,
    output logic [INDEX_BITS-1:0]  o_netz
);

    logic                  r_valid;
    logic [INDEX_BITS-1:0] r_idx;
    crtc_pkg::t_rems       r_rems;
    logic [INDEX_BITS-1:0] r_node;
    logic [INDEX_BITS-1:0] r_rtr;
    logic [INDEX_BITS-1:0] r_netz;

    crtc_pkg::t_rems          n_rems;
    logic [crtc_pkg::NUM_DIV:0] w_q;

    // quotient bit of each divider feeds the next one in the same column
    always_comb begin
        logic [6:0] s;
        w_q[0] = i_idx[INDEX_BITS-1];
        for (int k = 0; k < crtc_pkg::NUM_DIV; k++) begin
            s = crtc_pkg::div_step(i_rems[k], w_q[k], i_cfg.div[k]);
            w_q[k+1] = s[6];
            n_rems[k] = s[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx  <= {i_idx[INDEX_BITS-2:0], 1'b0};
            r_rems <= n_rems;
            r_node <= {i_node[INDEX_BITS-2:0], w_q[crtc_pkg::DIV_NOC_Z+1]};
            r_rtr  <= {i_rtr[INDEX_BITS-2:0], w_q[crtc_pkg::DIV_NODE+1]};
            r_netz <= {i_netz[INDEX_BITS-2:0], w_q[crtc_pkg::DIV_NET_Y+1]};
        end
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_rems  = r_rems;
    assign o_node  = r_node;
    assign o_rtr   = r_rtr;
    assign o_netz  = r_netz;

endmodule
`default_nettype wire

// ----- sv/crtc_out.sv -----
`default_nettype none
module crtc_out #(
    parameter int INDEX_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire crtc_pkg::t_cfg   i_cfg,
    input  wire                   i_valid,
    input  wire crtc_pkg::t_rems  i_rems,
    input  wire [INDEX_BITS-1:0]  i_node,
    input  wire [INDEX_BITS-1:0]  i_rtr,
    input  wire [INDEX_BITS-1:0]  i_netz,
    input  wire                   i_ready,
    output logic                  o_en,
    output logic                  o_valid,
    output logic [5:0]            o_net_x,
    output logic [5:0]            o_net_y,
    output logic [31:0]           o_net_z,
    output logic [5:0]            o_noc_x,
    output logic [5:0]            o_noc_y,
    output logic [5:0]            o_noc_z,
    output logic [31:0]           o_node_number,
    output logic [31:0]           o_router_number,
    output logic                  o_out_of_range
);

    logic r_valid;
    logic [13:0] w_zprod;

    assign o_en = !r_valid || i_ready;

    // noc z = (node mod nodes_per_router) * on-chip z size + in-node z
    assign w_zprod = 14'(i_rems[crtc_pkg::DIV_NODE]) * 14'(i_cfg.div[crtc_pkg::DIV_NOC_Z])
                   + 14'(i_rems[crtc_pkg::DIV_NOC_Z]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            o_net_x         <= i_rems[crtc_pkg::DIV_NET_X];
            o_net_y         <= i_rems[crtc_pkg::DIV_NET_Y];
            o_net_z         <= 32'(i_netz);
            o_noc_x         <= i_rems[crtc_pkg::DIV_NOC_X];
            o_noc_y         <= i_rems[crtc_pkg::DIV_NOC_Y];
            o_noc_z         <= w_zprod[5:0];
            o_node_number   <= 32'(i_node);
            o_router_number <= 32'(i_rtr);
            o_out_of_range  <= i_netz >= INDEX_BITS'(i_cfg.depth);
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ----- sv/core_rank_to_topology_coords.sv -----
`default_nettype none
// Core rank to two-level machine coordinates.
// Input channel: i_valid/o_ready carry one core index per beat; only the low
// INDEX_BITS bits count. Output channel: o_valid/i_ready carry the outer and
// on-chip coordinates, node and router numbers and the range flag.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one radix register per
// cycle; 0 is taken as 1 and values above 64 as 64. Write only while idle.
// The index is divided by the seven radices as a chain of bit-serial long
// divisions, one index bit per pipeline stage, MSB first.
// Path: each beat passes through the stage registers, then the output register.
// Throughput: one beat per cycle while the pipeline is not stalled.
// Stall: the whole pipeline holds while the output register is full and
// i_ready is low; bubbles are not squeezed out.
// Reset: pipeline empties, all radix registers return to 1.
module core_rank_to_topology_coords #(
    parameter int INDEX_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [6:0]   i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [31:0]  i_core_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [5:0]  o_net_x,
    output logic [5:0]  o_net_y,
    output logic [31:0] o_net_z,
    output logic [5:0]  o_noc_x,
    output logic [5:0]  o_noc_y,
    output logic [5:0]  o_noc_z,
    output logic [31:0] o_node_number,
    output logic [31:0] o_router_number,
    output logic        o_out_of_range
);

    crtc_pkg::t_cfg w_cfg;
    logic           w_en;

    logic                  w_valid [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] w_idx   [INDEX_BITS+1];
    crtc_pkg::t_rems       w_rems  [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] w_node  [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] w_rtr   [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] w_netz  [INDEX_BITS+1];

    crtc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign o_ready = w_en;

    assign w_valid[0] = i_valid;
    assign w_idx[0]   = INDEX_BITS'(i_core_index);
    assign w_rems[0]  = '0;
    assign w_node[0]  = '0;
    assign w_rtr[0]   = '0;
    assign w_netz[0]  = '0;

    for (genvar g = 0; g < INDEX_BITS; g++) begin : g_stage
        crtc_stage #(
            .INDEX_BITS (INDEX_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_valid (w_valid[g]),
            .i_idx   (w_idx[g]),
            .i_rems  (w_rems[g]),
            .i_node  (w_node[g]),
            .i_rtr   (w_rtr[g]),
            .i_netz  (w_netz[g]),
            .o_valid (w_valid[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_rems  (w_rems[g+1]),
            .o_node  (w_node[g+1]),
            .o_rtr   (w_rtr[g+1]),
            .o_netz  (w_netz[g+1])
        );
    end

    crtc_out #(
        .INDEX_BITS (INDEX_BITS)
    ) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (w_valid[INDEX_BITS]),
        .i_rems          (w_rems[INDEX_BITS]),
        .i_node          (w_node[INDEX_BITS]),
        .i_rtr           (w_rtr[INDEX_BITS]),
        .i_netz          (w_netz[INDEX_BITS]),
        .i_ready         (i_ready),
        .o_en            (w_en),
        .o_valid         (o_valid),
        .o_net_x         (o_net_x),
        .o_net_y         (o_net_y),
        .o_net_z         (o_net_z),
        .o_noc_x         (o_noc_x),
        .o_noc_y         (o_noc_y),
        .o_noc_z         (o_noc_z),
        .o_node_number   (o_node_number),
        .o_router_number (o_router_number),
        .o_out_of_range  (o_out_of_range)
    );

endmodule
`default_nettype wire

// ----- test/core_rank_to_topology_coords_chk.sv -----
`default_nettype none
module core_rank_to_topology_coords_chk (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [6:0]   i_cfg_data,
    input  wire         i_valid,
    input  wire         i_in_ready,
    input  wire [31:0]  i_core_index,
    input  wire         i_out_valid,
    input  wire         i_ready,
    input  wire [5:0]   i_net_x,
    input  wire [5:0]   i_net_y,
    input  wire [31:0]  i_net_z,
    input  wire [5:0]   i_noc_x,
    input  wire [5:0]   i_noc_y,
    input  wire [5:0]   i_noc_z,
    input  wire [31:0]  i_node_number,
    input  wire [31:0]  i_router_number,
    input  wire         i_out_of_range,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [5:0]  net_x;
        logic [5:0]  net_y;
        logic [31:0] net_z;
        logic [5:0]  noc_x;
        logic [5:0]  noc_y;
        logic [5:0]  noc_z;
        logic [31:0] node;
        logic [31:0] router;
        logic        oor;
    } t_coords;

    logic [6:0] radix [8];
    t_coords    coords_q [$];

    function automatic logic [63:0] eff_radix(input logic [6:0] v);
        logic [63:0] r;
        if (v == 7'd0) begin
            r = 64'd1;
        end else if (v > 7'd64) begin
            r = 64'd64;
        end else begin
            r = 64'(v);
        end
        return r;
    endfunction

    function automatic t_coords locate_core(input logic [31:0] idx_in);
        logic [63:0] idx, nw, nh, nd, cw, ch, cd, cr, npr;
        logic [63:0] per_node, per_rtr, row, plane, total, crow, cplane, np, c, cp, node;
        t_coords t;
        idx = {32'd0, idx_in};
        nw = eff_radix(radix[crtc_pkg::REG_NET_WIDTH]);
        nh = eff_radix(radix[crtc_pkg::REG_NET_HEIGHT]);
        nd = eff_radix(radix[crtc_pkg::REG_NET_DEPTH]);
        cw = eff_radix(radix[crtc_pkg::REG_NOC_WIDTH]);
        ch = eff_radix(radix[crtc_pkg::REG_NOC_HEIGHT]);
        cd = eff_radix(radix[crtc_pkg::REG_NOC_ZDIM]);
        cr = eff_radix(radix[crtc_pkg::REG_CORES_RTR]);
        npr = eff_radix(radix[crtc_pkg::REG_NODES_RTR]);
        per_node = cw * ch * cd * cr;
        per_rtr = per_node * npr;
        row = nw * per_rtr;
        plane = row * nh;
        total = plane * nd;
        crow = cw * cr;
        cplane = crow * ch;
        np = idx % plane;
        c = idx % per_rtr;
        cp = c % cplane;
        node = idx / per_node;
        t.net_x = 6'((np % row) / per_rtr);
        t.net_y = 6'(np / row);
        t.net_z = 32'(idx / plane);
        t.noc_x = 6'((cp % crow) / cr);
        t.noc_y = 6'(cp / crow);
        t.noc_z = 6'(c / cplane);
        t.node = 32'(node);
        t.router = 32'(node / npr);
        t.oor = idx >= total;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_coords w;
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) radix[k] <= 7'd1;
        end else begin
            if (i_cfg_we) radix[i_cfg_idx] <= i_cfg_data;
            if (i_valid && i_in_ready) coords_q = {coords_q, locate_core(i_core_index)};
            if (i_out_valid && i_ready) begin
                o_results++;
                if (coords_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    w = coords_q.pop_front();
                    if (i_net_x !== w.net_x) report_mismatch("net_x", i_net_x, w.net_x);
                    if (i_net_y !== w.net_y) report_mismatch("net_y", i_net_y, w.net_y);
                    if (i_net_z !== w.net_z) report_mismatch("net_z", i_net_z, w.net_z);
                    if (i_noc_x !== w.noc_x) report_mismatch("noc_x", i_noc_x, w.noc_x);
                    if (i_noc_y !== w.noc_y) report_mismatch("noc_y", i_noc_y, w.noc_y);
                    if (i_noc_z !== w.noc_z) report_mismatch("noc_z", i_noc_z, w.noc_z);
                    if (i_node_number !== w.node)
                        report_mismatch("node_number", i_node_number, w.node);
                    if (i_router_number !== w.router)
                        report_mismatch("router_number", i_router_number, w.router);
                    if (i_out_of_range !== w.oor)
                        report_mismatch("out_of_range", i_out_of_range, w.oor);
                end
            end
        end
        o_pending = coords_q.size();
    end
endmodule
`default_nettype wire

// ----- test/core_rank_to_topology_coords_tb.sv -----
`default_nettype none
module core_rank_to_topology_coords_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [6:0]  cfg_data = 0;
    logic        core_valid = 0;
    logic [31:0] core_index = 0;
    logic        coords_ready = 0;
    logic        o_ready, o_valid, o_out_of_range;
    logic [5:0]  o_net_x, o_net_y, o_noc_x, o_noc_y, o_noc_z;
    logic [31:0] o_net_z, o_node_number, o_router_number;
    int          errors, pending, results;
    int          cycles = 0;
    int          send_idle = 0, recv_stall = 0;
    int          hold_off = 0;
    int          ncfg = 0;

    core_rank_to_topology_coords i_dut (
        .i_clk, .i_rst_n, .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(core_valid), .o_ready, .i_core_index(core_index),
        .o_valid, .i_ready(coords_ready), .o_net_x, .o_net_y, .o_net_z,
        .o_noc_x, .o_noc_y, .o_noc_z, .o_node_number, .o_router_number, .o_out_of_range
    );

    core_rank_to_topology_coords_chk i_chk (
        .i_clk, .i_rst_n, .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(core_valid), .i_in_ready(o_ready), .i_core_index(core_index),
        .i_out_valid(o_valid), .i_ready(coords_ready), .i_net_x(o_net_x),
        .i_net_y(o_net_y), .i_net_z(o_net_z), .i_noc_x(o_noc_x), .i_noc_y(o_noc_y),
        .i_noc_z(o_noc_z), .i_node_number(o_node_number),
        .i_router_number(o_router_number), .i_out_of_range(o_out_of_range),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls by percentage, or a long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            coords_ready <= 1'b0;
        end else begin
            coords_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // write enable stays high across a burst of writes; the caller drops it
    task automatic write_radix(input crtc_pkg::t_reg_idx idx, input logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        ncfg++;
    endtask

    // valid stays high into the next beat unless the sender idles
    task automatic send_core(input logic [31:0] idx);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            core_valid <= 1'b0;
            @(posedge i_clk);
        end
        core_valid <= 1'b1;
        core_index <= idx;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_pipe();
        core_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one configuration phase: write all radices, then a batch of indexes
    task automatic run_phase(input logic [6:0] v [8], input int n, input logic [31:0] span,
                             input int stretch);
        logic [31:0] total;
        drain_pipe();
        for (int k = 0; k < 8; k++) write_radix(crtc_pkg::t_reg_idx'(k), v[k]);
        cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
        if (stretch > 0) hold_off <= stretch;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: total = $urandom;
                1: total = $urandom_range(span);
                2: total = span - $urandom_range(3);
                default: total = $urandom_range(span + (span >> 2));
            endcase
            send_core(total);
        end
    endtask

    logic [6:0] radix_set [8];

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes of the index at reset radices
        send_core(32'd0);
        send_core(32'd1);
        send_core(32'hFFFF_FFFF);
        send_core(32'h8000_0000);
        send_core(32'h5555_5555);
        send_core(32'hAAAA_AAAA);
        // all radices at the maximum
        radix_set = '{7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64};
        run_phase(radix_set, 0, 0, 0);
        send_core(32'd0);
        send_core(32'hFFFF_FFFF);
        send_core(32'd16777215);
        send_core(32'd16777216);
        // out-of-range register values: zero acts as one, large as 64
        radix_set = '{7'd0, 7'd127, 7'd65, 7'd0, 7'd100, 7'd3, 7'd0, 7'd2};
        run_phase(radix_set, 0, 0, 0);
        send_core(32'd0);
        send_core(32'd12345);
        send_core(32'hFFFF_FFFF);
        // small machine with index at the range edge
        radix_set = '{7'd2, 7'd3, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2};
        run_phase(radix_set, 0, 0, 0);
        send_core(32'd383);
        send_core(32'd384);
        send_core(32'd385);
        send_core(32'd7);
        // random phases, cycling through four idling modes
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 45; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 45; end
                default: begin send_idle = 23; recv_stall = 23; end
            endcase
            for (int k = 0; k < 8; k++)
                radix_set[k] = (ph == 15) ? 7'd1 : 7'($urandom_range(ph < 3 ? 127 : 8));
            run_phase(radix_set, 45, 32'($urandom_range(4000)), (ph == 5) ? 300 : 0);
        end
        drain_pipe();
        $display("Covered %0d results across %0d register writes and four idling modes,",
                 results, ncfg);
        $display("including a long output hold-off and radix extremes.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/crtc_pkg.sv
sv/crtc_cfg_regs.sv
sv/crtc_stage.sv
sv/crtc_out.sv
sv/core_rank_to_topology_coords.sv
test/core_rank_to_topology_coords_chk.sv
test/core_rank_to_topology_coords_tb.sv
